FILE: rtl/assert_macros.svh
// assertion macros used by quadratic_bezier_spline_eval.sv
// no dependencies; the bodies are empty when SYNTHESIS is set
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("assertion failed");
// condition must never be seen outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
	else $error("forbidden condition seen");
`else
`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)
`endif

`endif

FILE: rtl/qbse_pkg.sv
// constants, codes and pipeline stage types of the spline evaluator
// no dependencies
package qbse_pkg;

	localparam int MAX_POINTS = 64;
	localparam int IDX_W      = $clog2(MAX_POINTS);
	localparam int CNT_W      = $clog2(MAX_POINTS + 1);
	localparam int CFG_W      = 7;
	localparam int DATA_W     = 32;
	localparam int FRAC_W     = 16;
	localparam int T_W        = FRAC_W + 1;
	localparam int WGT_W      = 2 * FRAC_W + 1;
	localparam int LO_W       = FRAC_W;
	localparam int HI_W       = WGT_W - LO_W;
	localparam int PLO_W      = DATA_W + LO_W + 1;
	localparam int PHI_W      = DATA_W + HI_W + 1;
	localparam int PROD_W     = DATA_W + WGT_W + 1;
	localparam int ACC_W      = PROD_W + 2;
	localparam int SRCH_STEPS = CNT_W;
	localparam int DIV_STEPS  = T_W;

	// item kinds
	localparam logic [1:0] KIND_WR_MAIN = 2'd0;
	localparam logic [1:0] KIND_WR_CTRL = 2'd1;
	localparam logic [1:0] KIND_EVAL    = 2'd2;

	// result regions
	localparam logic [1:0] REGION_IN    = 2'd0;
	localparam logic [1:0] REGION_BELOW = 2'd1;
	localparam logic [1:0] REGION_ABOVE = 2'd2;

	// query classes found at the front
	localparam logic [1:0] CLS_BELOW  = 2'd0;
	localparam logic [1:0] CLS_ABOVE  = 2'd1;
	localparam logic [1:0] CLS_FIRST  = 2'd2;
	localparam logic [1:0] CLS_INSIDE = 2'd3;

	typedef struct packed {
		logic              vld;
		logic [1:0]        kind;
		logic [IDX_W-1:0]  idx;
		logic [DATA_W-1:0] ex;
		logic [DATA_W-1:0] ey;
		logic [DATA_W-1:0] qx;
		logic [CNT_W-1:0]  n;
		logic [1:0]        cls;
		logic [CNT_W-1:0]  lo;
		logic [CNT_W-1:0]  len;
	} srch_t;

	typedef struct packed {
		logic              vld;
		logic [1:0]        cls;
		logic [IDX_W-1:0]  seg;
		logic [DATA_W-1:0] qx;
	} blnd_t;

	typedef struct packed {
		logic              vld;
		logic [1:0]        cls;
		logic [IDX_W-1:0]  seg;
		logic [2:0][DATA_W-1:0] y;
		logic [DATA_W-1:0] wd;
		logic [DATA_W-1:0] rem;
		logic [T_W-1:0]    quo;
		logic              zw;
	} divs_t;

	typedef struct packed {
		logic              vld;
		logic [1:0]        cls;
		logic [IDX_W-1:0]  seg;
		logic [2:0][DATA_W-1:0] y;
		logic [2:0][WGT_W-1:0]  w;
	} wgt_t;

	typedef struct packed {
		logic              vld;
		logic [1:0]        cls;
		logic [IDX_W-1:0]  seg;
		logic [DATA_W-1:0] yl;
		logic [2:0][PLO_W-1:0] plo;
		logic [2:0][PHI_W-1:0] phi;
	} pp_t;

	typedef struct packed {
		logic              vld;
		logic [1:0]        cls;
		logic [IDX_W-1:0]  seg;
		logic [DATA_W-1:0] yl;
		logic [2:0][PROD_W-1:0] prd;
	} prd_t;

	typedef struct packed {
		logic              vld;
		logic [1:0]        cls;
		logic [IDX_W-1:0]  seg;
		logic [DATA_W-1:0] yl;
		logic [ACC_W-1:0]  acc;
	} sum_t;

endpackage

FILE: rtl/quadratic_bezier_spline_eval.sv
// piecewise quadratic bezier spline evaluator, fully pipelined
// depends on qbse_pkg and assert_macros.svh
//
// channel  dir  handshake            word
// in       in   in_valid/in_ready    kind, entry_index, entry_x, entry_y, query_x
// out      out  out_valid/out_ready  value, region, segment
// cfg      in   cfg_valid/cfg_ready  cfg_data (point_count)
//
// one word enters per cycle while the output is not stalled
// the pipe holds the 7-step binary search (a read stage and a compare stage a step,
// one x copy each), the 17-stage restoring divider for t and the 5-stage blend multiply and round
// all stages advance together; a stalled output freezes the whole pipe
// reset clears the valid bits and sets point_count to 1; tables are unknown
// until written
`include "assert_macros.svh"

module quadratic_bezier_spline_eval import qbse_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        kind,
	input  logic [5:0]        entry_index,
	input  logic [31:0]       entry_x,
	input  logic [31:0]       entry_y,
	input  logic [31:0]       query_x,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [31:0]       value,
	output logic [1:0]        region,
	output logic [5:0]        segment,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [CFG_W-1:0]  cfg_data
);

	localparam logic [T_W-1:0]    ONE_T    = T_W'(1) << FRAC_W;
	localparam logic [ACC_W-1:0]  RND      = ACC_W'(1) << (2 * FRAC_W - 1);
	localparam logic [DATA_W-1:0] DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic [DATA_W-1:0] DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};

	// global advance: every stage moves when the output slot is free or taken
	logic en;
	logic out_vld_q;
	logic [DATA_W-1:0] value_q;
	logic [1:0]        region_q;
	logic [IDX_W-1:0]  seg_q;

	assign en        = !out_vld_q || out_ready;
	assign in_ready  = en;
	assign cfg_ready = 1'b1;

	// point count register
	logic [CFG_W-1:0] point_count_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_count_q <= CFG_W'(1);
		end else if (cfg_valid) begin
			point_count_q <= cfg_data;
		end
	end

	// active count, 0 acts as 1 and large values as the table depth
	logic [CNT_W-1:0] n_act;
	always_comb begin
		if (point_count_q == '0) begin
			n_act = CNT_W'(1);
		end else if (int'(point_count_q) > MAX_POINTS) begin
			n_act = CNT_W'(MAX_POINTS);
		end else begin
			n_act = CNT_W'(point_count_q);
		end
	end

	// stage 1: capture the word
	srch_t s1_s;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_s <= '0;
		end else if (en) begin
			s1_s.vld  <= in_valid;
			s1_s.kind <= kind;
			s1_s.idx  <= entry_index;
			s1_s.ex   <= entry_x;
			s1_s.ey   <= entry_y;
			s1_s.qx   <= query_x;
			s1_s.n    <= n_act;
			s1_s.cls  <= CLS_BELOW;
			s1_s.lo   <= '0;
			s1_s.len  <= '0;
		end
	end

	// first x and last x copies, written as main-point words pass stage 1
	logic [DATA_W-1:0] x0_q;
	logic [DATA_W-1:0] xlast_mem [MAX_POINTS];
	logic [DATA_W-1:0] x0_s2;
	logic [DATA_W-1:0] xlast_s2;
	logic              s1_wr_main;
	logic [CNT_W-1:0]  s1_nm1;

	assign s1_wr_main = s1_s.vld && (s1_s.kind == KIND_WR_MAIN);
	assign s1_nm1     = s1_s.n - CNT_W'(1);

	always_ff @(posedge clk) begin
		if (en) begin
			if (s1_wr_main) begin
				xlast_mem[s1_s.idx] <= s1_s.ex;
				if (s1_s.idx == '0) begin
					x0_q <= s1_s.ex;
				end
			end
			x0_s2    <= x0_q;
			xlast_s2 <= xlast_mem[s1_nm1[IDX_W-1:0]];
		end
	end

	// stage 2: classify the query against the table ends
	srch_t s2_s;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_s <= '0;
		end else if (en) begin
			s2_s <= s1_s;
		end
	end

	srch_t s2_nxt;
	always_comb begin
		s2_nxt     = s2_s;
		s2_nxt.lo  = '0;
		s2_nxt.len = s2_s.n;
		if ($signed(s2_s.qx) < $signed(x0_s2)) begin
			s2_nxt.cls = CLS_BELOW;
		end else if ($signed(s2_s.qx) > $signed(xlast_s2)) begin
			s2_nxt.cls = CLS_ABOVE;
		end else if (s2_s.qx == x0_s2 || s2_s.n < CNT_W'(2)) begin
			s2_nxt.cls = CLS_FIRST;
		end else begin
			s2_nxt.cls = CLS_INSIDE;
		end
	end

	// binary search (lower bound): each step reads its own x copy, then compares
	srch_t             sa_s [SRCH_STEPS+1];
	srch_t             sd_s [SRCH_STEPS];
	logic [DATA_W-1:0] xrd_s [SRCH_STEPS];
	logic [DATA_W-1:0] sx_mem [SRCH_STEPS][MAX_POINTS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sa_s[0] <= '0;
		end else if (en) begin
			sa_s[0] <= s2_nxt;
		end
	end

	for (genvar k = 0; k < SRCH_STEPS; k++) begin : g_srch
		logic [CNT_W-1:0] mid;
		logic [CNT_W-1:0] dmid;
		logic [CNT_W-1:0] dhalf;
		srch_t            upd;

		assign mid = sa_s[k].lo + (sa_s[k].len >> 1);

		always_ff @(posedge clk) begin
			if (en) begin
				if (sa_s[k].vld && sa_s[k].kind == KIND_WR_MAIN) begin
					sx_mem[k][sa_s[k].idx] <= sa_s[k].ex;
				end
				xrd_s[k] <= sx_mem[k][mid[IDX_W-1:0]];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sd_s[k] <= '0;
			end else if (en) begin
				sd_s[k] <= sa_s[k];
			end
		end

		assign dhalf = sd_s[k].len >> 1;
		assign dmid  = sd_s[k].lo + dhalf;

		always_comb begin
			upd = sd_s[k];
			if (sd_s[k].len != '0) begin
				if ($signed(xrd_s[k]) < $signed(sd_s[k].qx)) begin
					upd.lo  = dmid + CNT_W'(1);
					upd.len = sd_s[k].len - dhalf - CNT_W'(1);
				end else begin
					upd.len = dhalf;
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sa_s[k+1] <= '0;
			end else if (en) begin
				sa_s[k+1] <= upd;
			end
		end
	end

	// segment pick and table reads for the blend
	srch_t            rs;
	logic [CNT_W-1:0] rs_nm1;
	logic [CNT_W-1:0] r_sel;
	logic [CNT_W-1:0] r_m1;
	logic [IDX_W-1:0] addr_l;
	logic [IDX_W-1:0] addr_r;
	logic [IDX_W-1:0] seg_n;

	assign rs     = sa_s[SRCH_STEPS];
	assign rs_nm1 = rs.n - CNT_W'(1);

	always_comb begin
		r_sel = rs.lo;
		if (r_sel == '0) begin
			r_sel = CNT_W'(1);
		end
		if (r_sel > rs_nm1) begin
			r_sel = rs_nm1;
		end
		r_m1   = r_sel - CNT_W'(1);
		addr_r = r_sel[IDX_W-1:0];
		case (rs.cls)
			CLS_ABOVE: begin
				addr_l = rs_nm1[IDX_W-1:0];
				seg_n  = (rs.n >= CNT_W'(2)) ? IDX_W'(rs.n - CNT_W'(2)) : '0;
			end
			CLS_INSIDE: begin
				addr_l = r_m1[IDX_W-1:0];
				seg_n  = r_m1[IDX_W-1:0];
			end
			default: begin
				addr_l = '0;
				seg_n  = '0;
			end
		endcase
	end

	logic [DATA_W-1:0] xl_mem [MAX_POINTS];
	logic [DATA_W-1:0] xr_mem [MAX_POINTS];
	logic [DATA_W-1:0] yl_mem [MAX_POINTS];
	logic [DATA_W-1:0] yr_mem [MAX_POINTS];
	logic [DATA_W-1:0] cy_mem [MAX_POINTS];
	logic [DATA_W-1:0] xl_b, xr_b, yl_b, yr_b, cy_b;

	always_ff @(posedge clk) begin
		if (en) begin
			if (rs.vld && rs.kind == KIND_WR_MAIN) begin
				xl_mem[rs.idx] <= rs.ex;
				xr_mem[rs.idx] <= rs.ex;
				yl_mem[rs.idx] <= rs.ey;
				yr_mem[rs.idx] <= rs.ey;
			end
			if (rs.vld && rs.kind == KIND_WR_CTRL) begin
				cy_mem[rs.idx] <= rs.ey;
			end
			xl_b <= xl_mem[addr_l];
			xr_b <= xr_mem[addr_r];
			yl_b <= yl_mem[addr_l];
			yr_b <= yr_mem[addr_r];
			cy_b <= cy_mem[addr_l];
		end
	end

	// from here on only evaluate words stay valid
	blnd_t b_s;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b_s <= '0;
		end else if (en) begin
			b_s.vld <= rs.vld && (rs.kind == KIND_EVAL);
			b_s.cls <= rs.cls;
			b_s.seg <= seg_n;
			b_s.qx  <= rs.qx;
		end
	end

	// segment width and clamped offset
	logic signed [DATA_W:0] wd_full;
	logic signed [DATA_W:0] num_full;
	logic                   wd_pos;
	logic [DATA_W-1:0]      num_c;

	assign wd_full  = $signed({xr_b[DATA_W-1], xr_b}) - $signed({xl_b[DATA_W-1], xl_b});
	assign num_full = $signed({b_s.qx[DATA_W-1], b_s.qx}) - $signed({xl_b[DATA_W-1], xl_b});
	assign wd_pos   = !wd_full[DATA_W] && (wd_full != '0);

	always_comb begin
		if (num_full[DATA_W]) begin
			num_c = '0;
		end else if (num_full > wd_full) begin
			num_c = wd_full[DATA_W-1:0];
		end else begin
			num_c = num_full[DATA_W-1:0];
		end
	end

	// restoring divider, one quotient bit per stage: t = offset * 2^16 / width
	divs_t div_s [DIV_STEPS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_s[0] <= '0;
		end else if (en) begin
			div_s[0].vld  <= b_s.vld;
			div_s[0].cls  <= b_s.cls;
			div_s[0].seg  <= b_s.seg;
			div_s[0].y[0] <= yl_b;
			div_s[0].y[1] <= cy_b;
			div_s[0].y[2] <= yr_b;
			div_s[0].wd   <= wd_full[DATA_W-1:0];
			div_s[0].rem  <= num_c;
			div_s[0].quo  <= '0;
			div_s[0].zw   <= !wd_pos;
		end
	end

	for (genvar d = 0; d < DIV_STEPS; d++) begin : g_div
		logic [DATA_W:0] rem2;
		logic            take;
		divs_t           nxt;

		// first step tests the offset itself (only equal to width gives t = 1.0)
		assign rem2 = (d == 0) ? {1'b0, div_s[d].rem} : {div_s[d].rem, 1'b0};
		assign take = rem2 >= {1'b0, div_s[d].wd};

		always_comb begin
			nxt     = div_s[d];
			nxt.quo = {div_s[d].quo[T_W-2:0], take};
			if (take) begin
				nxt.rem = DATA_W'(rem2 - {1'b0, div_s[d].wd});
			end else begin
				nxt.rem = rem2[DATA_W-1:0];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				div_s[d+1] <= '0;
			end else if (en) begin
				div_s[d+1] <= nxt;
			end
		end
	end

	// blend weights (1-t)^2, 2(1-t)t, t^2 in Q1.32
	divs_t            dv;
	logic [T_W-1:0]   t_v;
	logic [T_W-1:0]   u_v;
	logic [2*T_W-1:0] uu_p, ut_p, tt_p;
	wgt_t             m1_s;

	assign dv   = div_s[DIV_STEPS];
	assign t_v  = dv.zw ? '0 : dv.quo;
	assign u_v  = ONE_T - t_v;
	assign uu_p = u_v * u_v;
	assign ut_p = u_v * t_v;
	assign tt_p = t_v * t_v;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m1_s <= '0;
		end else if (en) begin
			m1_s.vld  <= dv.vld;
			m1_s.cls  <= dv.cls;
			m1_s.seg  <= dv.seg;
			m1_s.y    <= dv.y;
			m1_s.w[0] <= uu_p[WGT_W-1:0];
			m1_s.w[1] <= {ut_p[WGT_W-2:0], 1'b0};
			m1_s.w[2] <= tt_p[WGT_W-1:0];
		end
	end

	// partial products: weight split in a low and a high half
	pp_t m2_s;
	logic signed [PLO_W-1:0] plo_v [3];
	logic signed [PHI_W-1:0] phi_v [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			plo_v[i] = $signed(m1_s.y[i]) * $signed({1'b0, m1_s.w[i][LO_W-1:0]});
			phi_v[i] = $signed(m1_s.y[i]) * $signed({1'b0, m1_s.w[i][WGT_W-1:LO_W]});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m2_s <= '0;
		end else if (en) begin
			m2_s.vld <= m1_s.vld;
			m2_s.cls <= m1_s.cls;
			m2_s.seg <= m1_s.seg;
			m2_s.yl  <= m1_s.y[0];
			for (int i = 0; i < 3; i++) begin
				m2_s.plo[i] <= plo_v[i];
				m2_s.phi[i] <= phi_v[i];
			end
		end
	end

	// recombine each product
	prd_t m3_s;
	logic signed [PROD_W-1:0] prd_v [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			prd_v[i] = ($signed(PROD_W'($signed(m2_s.phi[i]))) <<< LO_W)
				+ $signed(PROD_W'($signed(m2_s.plo[i])));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m3_s <= '0;
		end else if (en) begin
			m3_s.vld <= m2_s.vld;
			m3_s.cls <= m2_s.cls;
			m3_s.seg <= m2_s.seg;
			m3_s.yl  <= m2_s.yl;
			for (int i = 0; i < 3; i++) begin
				m3_s.prd[i] <= prd_v[i];
			end
		end
	end

	// sum of the three terms
	sum_t m4_s;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m4_s <= '0;
		end else if (en) begin
			m4_s.vld <= m3_s.vld;
			m4_s.cls <= m3_s.cls;
			m4_s.seg <= m3_s.seg;
			m4_s.yl  <= m3_s.yl;
			m4_s.acc <= ACC_W'($signed(m3_s.prd[0])) + ACC_W'($signed(m3_s.prd[1]))
				+ ACC_W'($signed(m3_s.prd[2]));
		end
	end

	// round half up, drop 32 fraction bits, saturate, pick clamp value
	logic [ACC_W-1:0]  rnd_v;
	logic [ACC_W-2*FRAC_W-DATA_W:0] top_v;
	logic [DATA_W-1:0] sat_v;
	logic [DATA_W-1:0] res_v;
	logic [1:0]        reg_v;

	assign rnd_v = m4_s.acc + RND;
	assign top_v = rnd_v[ACC_W-1:2*FRAC_W+DATA_W-1];

	always_comb begin
		if (&top_v || ~|top_v) begin
			sat_v = rnd_v[2*FRAC_W+DATA_W-1:2*FRAC_W];
		end else if (rnd_v[ACC_W-1]) begin
			sat_v = DATA_MIN;
		end else begin
			sat_v = DATA_MAX;
		end
		res_v = (m4_s.cls == CLS_INSIDE) ? sat_v : m4_s.yl;
		case (m4_s.cls)
			CLS_BELOW: reg_v = REGION_BELOW;
			CLS_ABOVE: reg_v = REGION_ABOVE;
			default:   reg_v = REGION_IN;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (en) begin
			out_vld_q <= m4_s.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			value_q  <= res_v;
			region_q <= reg_v;
			seg_q    <= m4_s.seg;
		end
	end

	assign out_valid = out_vld_q;
	assign value     = value_q;
	assign region    = region_q;
	assign segment   = seg_q;

	// a clamp-below result always reports segment zero
	`ASSERT_CLK(a_below_seg0, clk, arst_n, out_valid && region == REGION_BELOW |-> segment == '0)
	// a refused word leaves the front stage untouched
	`ASSERT_CLK(a_stall_hold, clk, arst_n, !in_ready |=> $stable(s1_s))
	// the search never runs past the active count
	`ASSERT_NEVER(a_lo_bound, clk, arst_n, rs.vld && rs.lo > rs.n)

endmodule
